// ----- rtl/core/bba_pkg.sv -----
`default_nettype none
package bba_pkg;

  // heap size is fixed by the word fields below
  localparam int MAX_ORDER = 16;

  typedef enum logic [1:0] {
    ST_FREE     = 2'd0,
    ST_OCCUPIED = 2'd1,
    ST_SPLIT    = 2'd2
  } node_state_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_SPACE = 2'd1,
    STATUS_BAD_FREE = 2'd2
  } status_t;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef struct packed {
    logic        command;
    logic [16:0] request_bytes;
    logic [15:0] block_offset;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] granted_offset;
    logic [4:0]  block_order;
    logic [16:0] bytes_used;
  } out_word_t;

endpackage
`default_nettype wire

// ----- rtl/core/bba_ram.sv -----
`default_nettype none
module bba_ram #(
  parameter int Width = 2,
  parameter int Depth = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/core/buddy_block_allocator.sv -----
`default_nettype none
// buddy allocator over a heap of 2^MAX_ORDER bytes, smallest block 2^MIN_ORDER bytes.
// the node tree (2^(MAX_ORDER-MIN_ORDER+1)-1 two-bit entries) sits in one ram with one write
// and one registered read port. after reset a clearing pass writes every node free, busy is
// high meanwhile. an allocate of a bad size answers no_space without a search. otherwise it
// tests the nodes of the wanted level one by one from the left: it reads a candidate, then
// reads its ancestors while its path stays open, then writes the candidate occupied and each
// ancestor split. a free walks down from the root, one node a level (at most levels+1), and
// merges upward while the buddy is free. a done state follows the last step and the result
// then sits on out_valid for one cycle; the receiver cannot hold it off.
module buddy_block_allocator #(
  parameter int MIN_ORDER = 4
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire bba_pkg::in_word_t  in_word,
  output logic                    out_valid,
  output bba_pkg::out_word_t      out_word
);
  localparam int MAX_ORDER = bba_pkg::MAX_ORDER;
  localparam int Levels = MAX_ORDER - MIN_ORDER;
  localparam int AW     = Levels + 1;
  localparam int Depth  = 1 << AW;
  localparam int LW     = $clog2(Levels + 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE,
    S_A_SCAN, S_A_PATH, S_A_PATHW, S_A_MARK,
    S_F_DOWN, S_F_DOWNW, S_F_BUD, S_F_BUDW, S_F_PAR, S_F_PARW,
    S_DONE
  } state_t;

  state_t          state_r;
  logic [AW-1:0]   clr_r;
  logic [AW-1:0]   node_r;      // node under inspection (0-based heap index)
  logic [AW-1:0]   walk_r;      // ancestor walker
  logic [LW-1:0]   lvl_r;       // target level
  logic [LW-1:0]   dlvl_r;      // free walk level
  logic [4:0]      ord_r;
  logic [15:0]     off_r;
  logic [16:0]     used_r;
  logic [AW-1:0]   last_r;      // last node of the target level
  logic            bud_free_r;

  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [1:0]      wdata, rdata;

  bba_ram #(.Width(2), .Depth(Depth)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // rounded order for an allocate
  logic [5:0] req_ord;
  always_comb begin
    req_ord = 6'(MIN_ORDER);
    for (int k = 16; k >= 0; k--) begin
      if (k >= MIN_ORDER && (17'(1) << k) >= in_word.request_bytes) begin
        req_ord = 6'(k);
      end
    end
    if (in_word.request_bytes > 17'h10000) begin
      req_ord = 6'd17;
    end
  end

  function automatic logic [AW-1:0] parent_of(input logic [AW-1:0] n);
    parent_of = (n - AW'(1)) >> 1;
  endfunction

  logic [AW-1:0] par_node;
  assign par_node = parent_of(node_r);

  // heap index of the first node at the target level
  logic [AW-1:0] lvl_first;
  assign lvl_first = (AW'(1) << lvl_r) - AW'(1);

  always_comb begin
    we    = 1'b0;
    waddr = walk_r;
    wdata = bba_pkg::ST_FREE;
    raddr = walk_r;
    unique case (state_r)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_r;
      end
      S_A_MARK: begin
        we    = 1'b1;
        waddr = walk_r;
        wdata = (walk_r == node_r) ? bba_pkg::ST_OCCUPIED : bba_pkg::ST_SPLIT;
      end
      S_F_PAR: begin
        we    = bud_free_r && rdata == bba_pkg::ST_SPLIT;
        waddr = par_node;
      end
      S_F_DOWN: begin
        we    = rdata == bba_pkg::ST_OCCUPIED;
        waddr = node_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_r     <= '0;
      used_r    <= '0;
      out_valid <= 1'b0;
      busy      <= 1'b1;
    end else begin
      out_valid <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(Depth - 2)) begin
            state_r <= S_IDLE;
            busy    <= 1'b0;
          end
        end
        S_IDLE: begin
          if (start) begin
            busy <= 1'b1;
            out_word.granted_offset <= '0;
            out_word.block_order    <= '0;
            if (in_word.command == bba_pkg::CMD_ALLOC) begin
              if (in_word.request_bytes == '0 || req_ord > 6'(MAX_ORDER)) begin
                out_word.status <= bba_pkg::STATUS_NO_SPACE;
                state_r <= S_DONE;
              end else begin
                ord_r   <= req_ord[4:0];
                lvl_r   <= LW'(6'(MAX_ORDER) - req_ord);
                node_r  <= (AW'(1) << (6'(MAX_ORDER) - req_ord)) - AW'(1);
                last_r  <= (AW'(2) << (6'(MAX_ORDER) - req_ord)) - AW'(2);
                walk_r  <= (AW'(1) << (6'(MAX_ORDER) - req_ord)) - AW'(1);
                state_r <= S_A_SCAN;
              end
            end else begin
              off_r   <= in_word.block_offset;
              dlvl_r  <= '0;
              node_r  <= '0;
              walk_r  <= '0;
              state_r <= S_F_DOWNW;
            end
          end
        end
        // rdata holds state of walk_r
        S_A_SCAN: state_r <= S_A_PATH;
        S_A_PATH: begin
          if (walk_r == node_r && rdata != bba_pkg::ST_FREE) begin
            // candidate taken: next one
            if (node_r == last_r) begin
              out_word.status <= bba_pkg::STATUS_NO_SPACE;
              state_r <= S_DONE;
            end else begin
              node_r  <= node_r + AW'(1);
              walk_r  <= node_r + AW'(1);
              state_r <= S_A_SCAN;
            end
          end else if (walk_r != node_r && rdata == bba_pkg::ST_OCCUPIED) begin
            if (node_r == last_r) begin
              out_word.status <= bba_pkg::STATUS_NO_SPACE;
              state_r <= S_DONE;
            end else begin
              node_r  <= node_r + AW'(1);
              walk_r  <= node_r + AW'(1);
              state_r <= S_A_SCAN;
            end
          end else if (walk_r == '0) begin
            walk_r  <= node_r;
            state_r <= S_A_MARK;
          end else begin
            walk_r  <= parent_of(walk_r);
            state_r <= S_A_PATHW;
          end
        end
        S_A_PATHW: state_r <= S_A_PATH;
        S_A_MARK: begin
          if (walk_r == '0) begin
            used_r <= used_r + (17'(1) << ord_r);
            out_word.status         <= bba_pkg::STATUS_OK;
            out_word.granted_offset <= 16'(32'(node_r - lvl_first) << ord_r);
            out_word.block_order    <= ord_r;
            state_r <= S_DONE;
          end else begin
            walk_r <= parent_of(walk_r);
          end
        end
        S_F_DOWNW: state_r <= S_F_DOWN;
        S_F_DOWN: begin
          if (rdata == bba_pkg::ST_OCCUPIED) begin
            ord_r  <= 5'(MAX_ORDER - int'(dlvl_r));
            used_r <= used_r - (17'(1) << (MAX_ORDER - int'(dlvl_r)));
            out_word.status      <= bba_pkg::STATUS_OK;
            out_word.block_order <= 5'(MAX_ORDER - int'(dlvl_r));
            if (node_r == '0) begin
              state_r <= S_DONE;
            end else begin
              walk_r  <= node_r[0] ? node_r + AW'(1) : node_r - AW'(1);
              state_r <= S_F_BUDW;
            end
          end else if (rdata == bba_pkg::ST_FREE || dlvl_r == LW'(Levels)) begin
            out_word.status <= bba_pkg::STATUS_BAD_FREE;
            state_r <= S_DONE;
          end else begin
            dlvl_r <= dlvl_r + LW'(1);
            node_r <= ((AW'(2) << dlvl_r) - AW'(1)) +
                      AW'(32'(off_r) >> (MAX_ORDER - int'(dlvl_r) - 1));
            walk_r <= ((AW'(2) << dlvl_r) - AW'(1)) +
                      AW'(32'(off_r) >> (MAX_ORDER - int'(dlvl_r) - 1));
            state_r <= S_F_DOWNW;
          end
        end
        S_F_BUDW: state_r <= S_F_BUD;
        S_F_BUD: begin
          bud_free_r <= rdata == bba_pkg::ST_FREE;
          walk_r     <= par_node;
          state_r    <= S_F_PARW;
        end
        S_F_PARW: state_r <= S_F_PAR;
        S_F_PAR: begin
          if (bud_free_r && rdata == bba_pkg::ST_SPLIT && par_node != '0) begin
            node_r  <= par_node;
            walk_r  <= par_node[0] ? par_node + AW'(1) : par_node - AW'(1);
            state_r <= S_F_BUDW;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          out_word.bytes_used <= used_r;
          out_valid <= 1'b1;
          busy      <= 1'b0;
          state_r   <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  ap_busy_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> busy) else $error("idle during clear");
  ap_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("double result");
  ap_used_cap: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= 17'h10000) else $error("used overflow");
  ap_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");
endmodule
`default_nettype wire
